// File: hdl/tobuddy_pkg.sv
// Package for the three-order buddy allocator.
// Holds status codes, operation codes and controller/datapath command structs.
// No dependencies.
package tobuddy_pkg;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_MEM  = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ORDER_MAX  = 2'd2;
    localparam logic [1:0] MARK_TAKEN = 2'd3;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,       // capture request
        DP_INIT_STEP,  // clear pass: one chunk mark and order-2 entry
        DP_POP,        // pop stack of current order (check count)
        DP_POP_DATA,   // take read data as got
        DP_SPLIT,      // push buddy half at order-1
        DP_TAKE,       // mark got as taken
        DP_MARK_RD,    // read mark of buddy
        DP_SRCH_RD,    // read stack entry at search pointer
        DP_SRCH_CMP,   // compare entry
        DP_MOVE_RD,    // read top entry
        DP_MOVE_WR,    // write top into found slot, merge
        DP_PUSH        // write mark and push final block
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic init_done;
        logic req_invalid;   // bad order or index
        logic req_free;
        logic stack_empty;   // current order stack empty
        logic at_req_order;  // split finished
        logic order_top;     // order == 2 or buddy out of pool
        logic mark_match;
        logic srch_end;
        logic srch_hit;
        logic hi_over;       // working order is 2 (alloc search at top order)
    } dp_status_t;

endpackage

// File: hdl/tobuddy_datapath.sv
// Datapath of the three-order buddy allocator: free stacks, counts, marks.
// Depends on tobuddy_pkg.
module tobuddy_datapath
    import tobuddy_pkg::*;
#(
    parameter int POOL_CHUNKS = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic       in_op,
    input  logic [1:0] in_order,
    input  logic [7:0] in_index,
    output dp_status_t stat,
    output logic [7:0] chunk_out,
    output logic [1:0] status_out
);

    localparam int GROUPED = ((POOL_CHUNKS + 3) / 4) * 4;
    localparam int DEPTH0  = GROUPED / 2;
    localparam int DEPTH1  = GROUPED / 4;
    localparam int AW      = (GROUPED > 2) ? $clog2(GROUPED) : 1;
    localparam int A0      = (DEPTH0 > 1) ? $clog2(DEPTH0) : 1;
    localparam int A1      = (DEPTH1 > 1) ? $clog2(DEPTH1) : 1;
    localparam int CW      = $clog2(DEPTH0 + 1);
    localparam int IW      = $clog2(GROUPED + 1);
    localparam int NGRP    = GROUPED / 4;
    // stack entries: split halves of a block near the top of the index range
    // run past 8 bits and are kept as they are
    localparam int EW      = 9;

    // memories
    logic [EW-1:0] stk0_mem [DEPTH0];
    logic [EW-1:0] stk1_mem [DEPTH1];
    logic [EW-1:0] stk2_mem [DEPTH1];
    logic [1:0]    mark_mem [GROUPED];

    logic [CW-1:0] cnt0_reg, cnt1_reg, cnt2_reg;
    logic [IW-1:0] init_reg;
    logic          init_done_reg;
    logic          op_reg;
    logic [1:0]    ord_reg;   // request order
    logic [1:0]    hi_reg;    // working order
    logic [7:0]    idx_reg;
    logic [EW-1:0] got_reg;
    logic [7:0]    bud_reg;
    logic [CW-1:0] ptr_reg;
    logic [EW-1:0] rd_reg;
    logic [1:0]    mrk_reg;
    logic [7:0]    chunk_reg;
    logic [1:0]    status_reg;
    logic          invalid_reg;
    logic          bud_out_reg;

    // current stack selection by hi_reg
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] cap_cur;
    always_comb
    begin
        case (hi_reg)
            2'd0:    begin cnt_cur = cnt0_reg; cap_cur = CW'(DEPTH0); end
            2'd1:    begin cnt_cur = cnt1_reg; cap_cur = CW'(DEPTH1); end
            default: begin cnt_cur = cnt2_reg; cap_cur = CW'(DEPTH1); end
        endcase
    end

    logic [1:0]    hm1;
    logic [EW-1:0] split_bud;
    logic [7:0]    free_bud;
    logic [8:0]    free_bud_w;
    assign hm1        = hi_reg - 2'd1;
    assign split_bud  = got_reg + (EW'(1) << hm1);
    assign free_bud   = idx_reg ^ (8'd1 << hi_reg);
    assign free_bud_w = {1'b0, free_bud};

    // count and capacity of order hi-1 for splits
    logic [CW-1:0] cnt_m1, cnt_cur_m1, cap_m1;
    always_comb
    begin
        case (hm1)
            2'd0:    begin cnt_m1 = cnt0_reg; cap_m1 = CW'(DEPTH0); end
            2'd1:    begin cnt_m1 = cnt1_reg; cap_m1 = CW'(DEPTH1); end
            default: begin cnt_m1 = cnt2_reg; cap_m1 = CW'(DEPTH1); end
        endcase
        cnt_cur_m1 = cnt_m1;
    end

    // stack access: read address and write
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic [1:0]    wr_ord;
    logic [CW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    always_comb
    begin
        rd_addr = ptr_reg;
        wr_en   = 1'b0;
        wr_ord  = hi_reg;
        wr_addr = cnt_cur;
        wr_data = {1'b0, idx_reg};
        case (cmd.op)
            DP_POP:      rd_addr = cnt_cur - CW'(1);
            DP_MOVE_RD:  rd_addr = cnt_cur - CW'(1);
            DP_INIT_STEP:
            begin
                wr_en   = (init_reg < IW'(NGRP));
                wr_ord  = ORDER_MAX;
                wr_addr = CW'(init_reg);
                wr_data = EW'({init_reg, 2'b00});
            end
            DP_SPLIT:
            begin
                wr_en   = (cnt_cur_m1 < cap_m1);
                wr_ord  = hm1;
                wr_addr = cnt_m1;
                wr_data = split_bud;
            end
            DP_MOVE_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_data = rd_reg;
            end
            DP_PUSH:
            begin
                wr_en = (cnt_cur < cap_cur);
            end
            default: ;
        endcase
    end

    // stack memories
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ord == 2'd0) stk0_mem[wr_addr[A0-1:0]] <= wr_data;
        if (wr_en && wr_ord == 2'd1) stk1_mem[wr_addr[A1-1:0]] <= wr_data;
        if (wr_en && wr_ord == 2'd2) stk2_mem[wr_addr[A1-1:0]] <= wr_data;
        case (hi_reg)
            2'd0:    rd_reg <= stk0_mem[rd_addr[A0-1:0]];
            2'd1:    rd_reg <= stk1_mem[rd_addr[A1-1:0]];
            default: rd_reg <= stk2_mem[rd_addr[A1-1:0]];
        endcase
    end

    // mark memory
    logic          mk_we;
    logic [AW-1:0] mk_addr;
    logic [1:0]    mk_data;
    always_comb
    begin
        mk_we   = 1'b0;
        mk_addr = AW'(bud_reg);
        mk_data = hm1;
        case (cmd.op)
            DP_INIT_STEP:
            begin
                mk_we   = (init_reg < IW'(GROUPED));
                mk_addr = AW'(init_reg);
                mk_data = (init_reg[1:0] == 2'd0 && init_reg < IW'(POOL_CHUNKS))
                          ? ORDER_MAX : 2'd0;
            end
            DP_SPLIT:
            begin
                mk_we   = ({1'b0, split_bud} < 10'(GROUPED));
                mk_addr = AW'(split_bud);
            end
            DP_TAKE:
            begin
                mk_we   = ({1'b0, got_reg} < 10'(GROUPED));
                mk_addr = AW'(got_reg);
                mk_data = MARK_TAKEN;
            end
            DP_MARK_RD:  mk_addr = AW'(free_bud);
            DP_PUSH:
            begin
                mk_we   = 1'b1;
                mk_addr = AW'(idx_reg);
                mk_data = hi_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mk_we) mark_mem[mk_addr] <= mk_data;
        mrk_reg <= mark_mem[mk_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            init_reg      <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                DP_INIT_STEP:
                begin
                    if (init_reg < IW'(NGRP) &&
                        {init_reg, 2'b00} < (IW + 2)'(POOL_CHUNKS))
                        cnt2_reg <= CW'(init_reg + IW'(1));
                    if (init_reg >= IW'(GROUPED - 1)) init_done_reg <= 1'b1;
                    else init_reg <= init_reg + IW'(1);
                end
                DP_POP:
                begin
                    if (cnt_cur != '0)
                    begin
                        case (hi_reg)
                            2'd0:    cnt0_reg <= cnt0_reg - CW'(1);
                            2'd1:    cnt1_reg <= cnt1_reg - CW'(1);
                            default: cnt2_reg <= cnt2_reg - CW'(1);
                        endcase
                    end
                end
                DP_SPLIT:
                begin
                    if (cnt_m1 < cap_m1)
                    begin
                        case (hm1)
                            2'd0:    cnt0_reg <= cnt0_reg + CW'(1);
                            2'd1:    cnt1_reg <= cnt1_reg + CW'(1);
                            default: cnt2_reg <= cnt2_reg + CW'(1);
                        endcase
                    end
                end
                DP_MOVE_WR:
                begin
                    case (hi_reg)
                        2'd0:    cnt0_reg <= cnt0_reg - CW'(1);
                        2'd1:    cnt1_reg <= cnt1_reg - CW'(1);
                        default: cnt2_reg <= cnt2_reg - CW'(1);
                    endcase
                end
                DP_PUSH:
                begin
                    if (cnt_cur < cap_cur)
                    begin
                        case (hi_reg)
                            2'd0:    cnt0_reg <= cnt0_reg + CW'(1);
                            2'd1:    cnt1_reg <= cnt1_reg + CW'(1);
                            default: cnt2_reg <= cnt2_reg + CW'(1);
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                op_reg      <= in_op;
                ord_reg     <= in_order;
                hi_reg      <= in_order;
                idx_reg     <= in_index;
                invalid_reg <= (in_order == MARK_TAKEN) ||
                               (in_op == OP_FREE && 17'(in_index) >= 17'(POOL_CHUNKS));
                chunk_reg   <= 8'd0;
                status_reg  <= STATUS_OK;
                if (in_order == MARK_TAKEN ||
                    (in_op == OP_FREE && 17'(in_index) >= 17'(POOL_CHUNKS)))
                    status_reg <= STATUS_INVALID;
            end
            DP_POP:
            begin
                if (cnt_cur == '0)
                begin
                    hi_reg <= hi_reg + 2'd1;
                    if (hi_reg == ORDER_MAX) status_reg <= STATUS_NO_MEM;
                end
            end
            DP_POP_DATA: got_reg <= rd_reg;
            DP_SPLIT:    hi_reg  <= hm1;
            DP_TAKE:     chunk_reg <= got_reg[7:0];
            DP_MARK_RD:
            begin
                bud_reg     <= free_bud;
                bud_out_reg <= (free_bud_w >= 9'(POOL_CHUNKS));
                ptr_reg     <= '0;
            end
            DP_SRCH_CMP:
            begin
                if (rd_reg != {1'b0, bud_reg}) ptr_reg <= ptr_reg + CW'(1);
            end
            DP_MOVE_WR:
            begin
                if (bud_reg < idx_reg) idx_reg <= bud_reg;
                hi_reg <= hi_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.init_done    = init_done_reg;
        stat.req_invalid  = invalid_reg;
        stat.req_free     = (op_reg == OP_FREE);
        stat.stack_empty  = (cnt_cur == '0);
        stat.at_req_order = (hi_reg == ord_reg);
        stat.order_top    = (hi_reg == ORDER_MAX) ||
                            (free_bud_w >= 9'(POOL_CHUNKS));
        stat.mark_match   = (mrk_reg == hi_reg) && !bud_out_reg;
        stat.srch_end     = (ptr_reg >= cnt_cur);
        stat.srch_hit     = (rd_reg == {1'b0, bud_reg});
        stat.hi_over      = (hi_reg == ORDER_MAX);
    end

    assign chunk_out  = chunk_reg;
    assign status_out = status_reg;

endmodule

// File: hdl/tobuddy_ctrl.sv
// Controller state machine for the three-order buddy allocator.
// Depends on tobuddy_pkg; drives tobuddy_datapath by command struct.
module tobuddy_ctrl
    import tobuddy_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t stat,
    input  logic       in_fire,
    input  logic       out_fire,
    output logic       in_ready,
    output logic       out_valid,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_POP, S_POP_DATA, S_SPLIT,
        S_TAKE, S_MARK, S_MARK_WAIT, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP,
        S_MOVE_RD, S_MOVE_WAIT, S_PUSH, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = DP_INIT_STEP;
                if (stat.init_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.req_invalid)  state_next = S_OUT;
                else if (stat.req_free) state_next = S_MARK;
                else                    state_next = S_POP;
            end
            S_POP:
            begin
                cmd.op = DP_POP;
                if (!stat.stack_empty) state_next = S_POP_DATA;
                else if (stat.hi_over) state_next = S_OUT;
            end
            S_POP_DATA:
            begin
                cmd.op     = DP_POP_DATA;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (stat.at_req_order) state_next = S_TAKE;
                else cmd.op = DP_SPLIT;
            end
            S_TAKE:
            begin
                cmd.op     = DP_TAKE;
                state_next = S_OUT;
            end
            S_MARK:
            begin
                if (stat.order_top) state_next = S_PUSH;
                else
                begin
                    cmd.op     = DP_MARK_RD;
                    state_next = S_MARK_WAIT;
                end
            end
            S_MARK_WAIT:
            begin
                if (stat.mark_match) state_next = S_SRCH_RD;
                else                 state_next = S_PUSH;
            end
            S_SRCH_RD:
            begin
                if (stat.srch_end) state_next = S_PUSH;
                else               state_next = S_SRCH_WAIT;
            end
            S_SRCH_WAIT: state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                cmd.op = DP_SRCH_CMP;
                if (stat.srch_hit) state_next = S_MOVE_RD;
                else               state_next = S_SRCH_RD;
            end
            S_MOVE_RD:
            begin
                cmd.op     = DP_MOVE_RD;
                state_next = S_MOVE_WAIT;
            end
            S_MOVE_WAIT:
            begin
                cmd.op     = DP_MOVE_WR;
                state_next = S_MARK;
            end
            S_PUSH:
            begin
                cmd.op     = DP_PUSH;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_INIT;
        else        state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // a result is never offered while a request is being taken
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready and valid both high");
    // a taken request always leads to dispatch
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_DISPATCH)
        else $error("request not dispatched");
    // result delivery returns to idle
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> in_ready)
        else $error("not idle after result");

endmodule

// File: hdl/three_order_buddy_allocator.sv
// Top level of the three-order buddy allocator.
// Depends on tobuddy_pkg, tobuddy_ctrl and tobuddy_datapath.
//
//  channel  | direction | tdata (low bit up)               | tuser
//  s_axis   | in        | order_code[1:0], block_index[9:2] | op
//  m_axis   | out       | chunk_index[7:0], status[9:8]     | -
//
// The result is offered straight after dispatch for an invalid request, once the
// order-2 stack is found empty for out of memory, and after up to three pops
// and two splits for an allocate. A free does, per merge level, a mark read and
// a search of the buddy's stack, entry by entry.
// After reset a clearing pass over ((POOL_CHUNKS+3)/4)*4 chunks sets marks
// and the order-2 stack; no transaction is accepted during it.
// One transaction in flight; the result waits until m_axis_tready.
module three_order_buddy_allocator
    import tobuddy_pkg::*;
#(
    parameter int POOL_CHUNKS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // order_code[1:0], block_index[9:2]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // chunk_index[7:0], status[9:8]
);

    dp_cmd_t    cmd;
    dp_status_t stat;
    logic       in_fire, out_fire;
    logic [7:0] chunk;
    logic [1:0] status;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    tobuddy_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    tobuddy_datapath #(.POOL_CHUNKS(POOL_CHUNKS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_op      (s_axis_tuser),
        .in_order   (s_axis_tdata[1:0]),
        .in_index   (s_axis_tdata[9:2]),
        .stat       (stat),
        .chunk_out  (chunk),
        .status_out (status)
    );

    assign m_axis_tdata = {6'd0, status, chunk};

endmodule
